>>> src/hfr_pkg.sv
// Shared types, codes and byte tables of the HTTP/2 frame receiver.
// No dependencies; every module of the receiver imports this package.
package hfr_pkg;

    // Fixed lengths of the protocol.
    localparam int PREFACE_LEN      = 24;
    localparam int HDR_LEN          = 9;
    localparam int SRV_LEN          = 27;
    localparam int MAX_RESULTS      = 32;
    localparam int STREAM_SLOTS_DEF = 16;
    localparam int PING_BYTES_DEF   = 8;

    // Reset value of the peer's concurrent stream limit.
    localparam logic [31:0] MAX_STREAMS_RST = 32'd100;

    // Frame types and the one settings identifier that is kept.
    localparam logic [7:0]  FT_DATA          = 8'd0;
    localparam logic [7:0]  FT_HEADERS       = 8'd1;
    localparam logic [7:0]  FT_SETTINGS      = 8'd4;
    localparam logic [7:0]  FT_PING          = 8'd6;
    localparam logic [7:0]  FT_WINDOW_UPDATE = 8'd8;
    localparam logic [15:0] SET_MAX_STREAMS  = 16'd3;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EVENT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EV_SETTINGS_ACK  = 3'd0,
        EV_PING_ACK      = 3'd1,
        EV_STREAM_OPENED = 3'd2,
        EV_TABLE_FULL    = 3'd3,
        EV_UNKNOWN_TYPE  = 3'd4,
        EV_PING_TOO_LONG = 3'd5,
        EV_WINDOW_UPDATE = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        PH_PREFACE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        TX_SERVER,
        TX_ACK,
        TX_PING
    } tx_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FEED,
        ST_FIN,
        ST_SCAN0,
        ST_SCAN,
        ST_SCAN_DONE,
        ST_TX,
        ST_RP_ADDR,
        ST_CE,
        ST_FLUSH
    } state_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [30:0] stream_ref;
        logic        end_stream;
        event_t      event_code;
        logic        run_last;
    } res_t;

    // Client connection preface, byte by byte.
    function automatic logic [7:0] preface_byte(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:    b = 8'h50;
            5'd1:    b = 8'h52;
            5'd2:    b = 8'h49;
            5'd3:    b = 8'h20;
            5'd4:    b = 8'h2A;
            5'd5:    b = 8'h20;
            5'd6:    b = 8'h48;
            5'd7:    b = 8'h54;
            5'd8:    b = 8'h54;
            5'd9:    b = 8'h50;
            5'd10:   b = 8'h2F;
            5'd11:   b = 8'h32;
            5'd12:   b = 8'h2E;
            5'd13:   b = 8'h30;
            5'd14:   b = 8'h0D;
            5'd15:   b = 8'h0A;
            5'd16:   b = 8'h0D;
            5'd17:   b = 8'h0A;
            5'd18:   b = 8'h53;
            5'd19:   b = 8'h4D;
            5'd20:   b = 8'h0D;
            5'd21:   b = 8'h0A;
            5'd22:   b = 8'h0D;
            5'd23:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Payload of the server SETTINGS frame: (1,4096), (2,0), (3,max streams).
    function automatic logic [7:0] srv_byte(input logic [4:0] j, input logic [31:0] pms);
        logic [7:0] b;
        case (j)
            5'd1:    b = 8'h01;
            5'd4:    b = 8'h10;
            5'd7:    b = 8'h02;
            5'd13:   b = 8'h03;
            5'd14:   b = pms[31:24];
            5'd15:   b = pms[23:16];
            5'd16:   b = pms[15:8];
            5'd17:   b = pms[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte i of a 9-byte frame header.
    function automatic logic [7:0] hdr_byte(input logic [3:0] i, input logic [23:0] len,
                                            input logic [7:0] ftype, input logic [7:0] flags,
                                            input logic [30:0] stream);
        logic [7:0] b;
        case (i)
            4'd0:    b = len[23:16];
            4'd1:    b = len[15:8];
            4'd2:    b = len[7:0];
            4'd3:    b = ftype;
            4'd4:    b = flags;
            4'd5:    b = {1'b0, stream[30:24]};
            4'd6:    b = stream[23:16];
            4'd7:    b = stream[15:8];
            4'd8:    b = stream[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/hfr_out_reg.sv
// Output register of the frame receiver: holds one result transaction so that
// the sequencer can hand it over while the consumer stalls. Depends on hfr_pkg.
module hfr_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  hfr_pkg::res_t in_res,
    output logic          out_valid,
    input  logic          out_ready,
    output hfr_pkg::res_t out_res
);
    import hfr_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // The register takes a new result whenever it is empty or being emptied.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

>>> src/hfr_core.sv
// Sequencer of the frame receiver: preface check, header and payload parsing,
// stream table and frame transmission around two memories. Depends on hfr_pkg.
module hfr_core #(
    parameter int STREAM_SLOTS = hfr_pkg::STREAM_SLOTS_DEF,
    parameter int PING_BYTES   = hfr_pkg::PING_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push_valid,
    input  logic          push_ready,
    output hfr_pkg::res_t push_res
);
    import hfr_pkg::*;

    localparam int BDEPTH = PREFACE_LEN + PING_BYTES;
    localparam int BW     = $clog2(BDEPTH);
    localparam int IW     = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int TX_MAX = (HDR_LEN + PING_BYTES > SRV_LEN) ? HDR_LEN + PING_BYTES : SRV_LEN;
    localparam int TW     = $clog2(TX_MAX + 1);
    localparam int CW     = $clog2(MAX_RESULTS + 1);

    // Control state.
    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic                    cstart_reg, cstart_next;
    logic [4:0]              pidx_reg, pidx_next;
    logic [63:0]             hs_reg, hs_next;
    logic [3:0]              hc_reg, hc_next;
    logic [23:0]             prem_reg, prem_next;
    logic [2:0]              ec_reg, ec_next;
    logic                    dk_reg, dk_next;
    logic                    pmask_reg, pmask_next;
    logic [31:0]             pms_reg, pms_next;
    logic                    rp_active_reg, rp_active_next;
    logic [STREAM_SLOTS-1:0] slot_valid_reg, slot_valid_next;

    // Datapath registers.
    logic [47:0]   es_reg, es_next;
    logic [23:0]   fr_len_reg, fr_len_next;
    logic [7:0]    fr_type_reg, fr_type_next;
    logic [7:0]    fr_flags_reg, fr_flags_next;
    logic [30:0]   fr_stream_reg, fr_stream_next;
    logic [31:0]   pend_reg, pend_next;
    logic [7:0]    byte_reg, byte_next;
    logic          ce_reg, ce_next;
    logic [4:0]    rp_i_reg, rp_i_next;
    logic [4:0]    rp_n_reg, rp_n_next;
    tx_mode_t      tx_mode_reg, tx_mode_next;
    logic [TW-1:0] tx_i_reg, tx_i_next;
    logic [IW-1:0] sc_i_reg, sc_i_next;
    logic          sc_found_reg, sc_found_next;
    logic          sc_ff_reg, sc_ff_next;
    logic [IW-1:0] sc_free_reg, sc_free_next;

    // Result hold register and per-transaction result count.
    res_t          hold_res_reg;
    logic          hold_valid_reg;
    logic [CW-1:0] cnt_reg;

    // Memories: preface hold and ping payload share the byte store.
    logic [7:0]  bmem [BDEPTH];
    logic [7:0]  bm_rdata;
    logic [30:0] smem [STREAM_SLOTS];
    logic [30:0] sm_rdata;

    logic          bm_we;
    logic [BW-1:0] bm_waddr, bm_raddr;
    logic [7:0]    bm_wdata;
    logic          sm_we;
    logic [IW-1:0] sm_raddr;

    logic    accept, emit_req, emit_go, flush_req, stall, do_ret;
    res_t    emit_res;
    logic [7:0]    fb;
    logic [63:0]   hs_sh;
    logic [3:0]    hc_inc;
    logic [47:0]   es_sh;
    logic [2:0]    ec_inc;
    logic [23:0]   pos;
    logic [23:0]   prem_dec;
    logic          hit;
    logic [TW-1:0] tx_total;
    logic [TW-1:0] ping_off;
    logic [7:0]    tx_byte;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fb       = rp_active_reg ? bm_rdata : byte_reg;
    assign hs_sh    = {hs_reg[55:0], fb};
    assign hc_inc   = hc_reg + 4'd1;
    assign es_sh    = {es_reg[39:0], fb};
    assign ec_inc   = ec_reg + 3'd1;
    assign pos      = fr_len_reg - prem_reg;
    assign prem_dec = prem_reg - 24'd1;
    assign hit      = slot_valid_reg[sc_i_reg] && (sm_rdata == fr_stream_reg);

    // Length and current byte of the frame being transmitted.
    always_comb begin
        case (tx_mode_reg)
            TX_SERVER: tx_total = TW'(SRV_LEN);
            TX_PING:   tx_total = TW'(HDR_LEN) + TW'(fr_len_reg);
            default:   tx_total = TW'(HDR_LEN);
        endcase
        ping_off = tx_i_reg - TW'(HDR_LEN - 1);
        if (tx_i_reg < TW'(HDR_LEN - 1) || ping_off >= TW'(PING_BYTES)) begin
            ping_off = '0;
        end
        if (tx_i_reg < TW'(HDR_LEN)) begin
            case (tx_mode_reg)
                TX_SERVER: tx_byte = hdr_byte(tx_i_reg[3:0], 24'd18, FT_SETTINGS, 8'd0, 31'd0);
                TX_PING:   tx_byte = hdr_byte(tx_i_reg[3:0], fr_len_reg, FT_PING, 8'd1,
                                              fr_stream_reg);
                default:   tx_byte = hdr_byte(tx_i_reg[3:0], 24'd0, FT_SETTINGS, 8'd1, 31'd0);
            endcase
        end else if (tx_mode_reg == TX_SERVER) begin
            tx_byte = srv_byte(5'(tx_i_reg - TW'(HDR_LEN)), pms_reg);
        end else begin
            tx_byte = bm_rdata;
        end
    end

    // Next state, memory accesses and result requests.
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cstart_next     = cstart_reg;
        pidx_next       = pidx_reg;
        hs_next         = hs_reg;
        hc_next         = hc_reg;
        prem_next       = prem_reg;
        ec_next         = ec_reg;
        dk_next         = dk_reg;
        pmask_next      = pmask_reg;
        pms_next        = pms_reg;
        rp_active_next  = rp_active_reg;
        slot_valid_next = slot_valid_reg;
        es_next         = es_reg;
        fr_len_next     = fr_len_reg;
        fr_type_next    = fr_type_reg;
        fr_flags_next   = fr_flags_reg;
        fr_stream_next  = fr_stream_reg;
        pend_next       = pend_reg;
        byte_next       = byte_reg;
        ce_next         = ce_reg;
        rp_i_next       = rp_i_reg;
        rp_n_next       = rp_n_reg;
        tx_mode_next    = tx_mode_reg;
        tx_i_next       = tx_i_reg;
        sc_i_next       = sc_i_reg;
        sc_found_next   = sc_found_reg;
        sc_ff_next      = sc_ff_reg;
        sc_free_next    = sc_free_reg;
        bm_we           = 1'b0;
        bm_waddr        = BW'(pidx_reg);
        bm_wdata        = byte_reg;
        bm_raddr        = BW'(rp_i_reg);
        sm_we           = 1'b0;
        sm_raddr        = '0;
        emit_req        = 1'b0;
        emit_res        = '0;
        emit_res.stream_ref = fr_stream_reg;
        flush_req       = 1'b0;
        do_ret          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next  = in_byte;
                    ce_next    = in_last;
                    state_next = ST_START;
                    if (cstart_reg) begin
                        cstart_next = 1'b0;
                        phase_next  = PH_PREFACE;
                        pidx_next   = 5'd0;
                    end
                end
            end

            // Preface check, or hand the byte to the parser.
            ST_START: begin
                if (phase_reg == PH_PREFACE) begin
                    bm_we     = 1'b1;
                    pidx_next = pidx_reg + 5'd1;
                    if (byte_reg != preface_byte(pidx_reg)) begin
                        rp_active_next = 1'b1;
                        rp_i_next      = 5'd0;
                        rp_n_next      = pidx_reg + 5'd1;
                        phase_next     = PH_HEADER;
                        state_next     = ST_RP_ADDR;
                    end else if (pidx_reg == 5'(PREFACE_LEN - 1)) begin
                        phase_next   = PH_HEADER;
                        tx_mode_next = TX_SERVER;
                        tx_i_next    = '0;
                        state_next   = ST_TX;
                    end else begin
                        state_next = ST_CE;
                    end
                end else begin
                    state_next = ST_FEED;
                end
            end

            ST_RP_ADDR: begin
                state_next = ST_FEED;
            end

            // One byte through the header or payload parser.
            ST_FEED: begin
                if (phase_reg != PH_PAYLOAD) begin
                    hs_next = hs_sh;
                    hc_next = hc_inc;
                    if (hc_inc == 4'd3) begin
                        fr_len_next = hs_sh[23:0];
                    end
                    if (hc_inc == 4'(HDR_LEN)) begin
                        hc_next        = 4'd0;
                        hs_next        = '0;
                        fr_type_next   = hs_sh[47:40];
                        fr_flags_next  = hs_sh[39:32];
                        fr_stream_next = hs_sh[30:0];
                        prem_next      = fr_len_reg;
                        es_next        = '0;
                        ec_next        = 3'd0;
                        pmask_next     = 1'b0;
                        if (hs_sh[47:40] == FT_DATA) begin
                            state_next = ST_SCAN0;
                        end else begin
                            dk_next = 1'b0;
                            if (fr_len_reg == 24'd0) begin
                                state_next = ST_FIN;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                do_ret     = 1'b1;
                            end
                        end
                    end else begin
                        do_ret = 1'b1;
                    end
                end else begin
                    prem_next = prem_dec;
                    if (fr_type_reg == FT_SETTINGS && !fr_flags_reg[0]) begin
                        es_next = es_sh;
                        ec_next = ec_inc;
                        if (ec_inc == 3'd6) begin
                            ec_next = 3'd0;
                            if (es_sh[47:32] == SET_MAX_STREAMS) begin
                                pend_next  = es_sh[31:0];
                                pmask_next = 1'b1;
                            end
                        end
                    end else if (fr_type_reg == FT_PING && !fr_flags_reg[0]) begin
                        if (pos < 24'(PING_BYTES)) begin
                            bm_we    = 1'b1;
                            bm_waddr = BW'(PREFACE_LEN) + BW'(pos);
                            bm_wdata = fb;
                        end
                    end else if (fr_type_reg == FT_DATA && dk_reg) begin
                        emit_req            = 1'b1;
                        emit_res.kind       = KIND_DATA;
                        emit_res.out_byte   = fb;
                        emit_res.frame_end  = (prem_dec == 24'd0);
                        emit_res.end_stream = fr_flags_reg[0];
                    end
                    if (prem_dec == 24'd0) begin
                        state_next = ST_FIN;
                    end else begin
                        do_ret = 1'b1;
                    end
                end
            end

            // Action of a completed frame.
            ST_FIN: begin
                phase_next    = PH_HEADER;
                emit_res.kind = KIND_EVENT;
                case (fr_type_reg)
                    FT_SETTINGS: begin
                        if (fr_flags_reg[0]) begin
                            emit_req            = 1'b1;
                            emit_res.event_code = EV_SETTINGS_ACK;
                            do_ret              = 1'b1;
                        end else begin
                            if (pmask_reg) begin
                                pms_next = pend_reg;
                            end
                            tx_mode_next = TX_ACK;
                            tx_i_next    = '0;
                            state_next   = ST_TX;
                        end
                    end
                    FT_PING: begin
                        if (fr_flags_reg[0]) begin
                            emit_req            = 1'b1;
                            emit_res.event_code = EV_PING_ACK;
                            do_ret              = 1'b1;
                        end else if (fr_len_reg > 24'(PING_BYTES)) begin
                            emit_req            = 1'b1;
                            emit_res.event_code = EV_PING_TOO_LONG;
                            do_ret              = 1'b1;
                        end else begin
                            tx_mode_next = TX_PING;
                            tx_i_next    = '0;
                            state_next   = ST_TX;
                        end
                    end
                    FT_HEADERS: begin
                        state_next = ST_SCAN0;
                    end
                    FT_DATA: begin
                        do_ret = 1'b1;
                    end
                    FT_WINDOW_UPDATE: begin
                        emit_req            = 1'b1;
                        emit_res.event_code = EV_WINDOW_UPDATE;
                        do_ret              = 1'b1;
                    end
                    default: begin
                        emit_req            = 1'b1;
                        emit_res.event_code = EV_UNKNOWN_TYPE;
                        do_ret              = 1'b1;
                    end
                endcase
            end

            // Stream table scan, one entry a cycle, each entry read in the cycle before.
            ST_SCAN0: begin
                sm_raddr      = '0;
                sc_i_next     = '0;
                sc_found_next = 1'b0;
                sc_ff_next    = 1'b0;
                state_next    = ST_SCAN;
            end

            ST_SCAN: begin
                if (!slot_valid_reg[sc_i_reg] && !sc_ff_reg) begin
                    sc_ff_next   = 1'b1;
                    sc_free_next = sc_i_reg;
                end
                if (hit || sc_i_reg == IW'(STREAM_SLOTS - 1)) begin
                    sc_found_next = hit;
                    state_next    = ST_SCAN_DONE;
                end else begin
                    sc_i_next = sc_i_reg + IW'(1);
                    sm_raddr  = sc_i_reg + IW'(1);
                end
            end

            ST_SCAN_DONE: begin
                if (fr_type_reg == FT_DATA) begin
                    dk_next = sc_found_reg;
                    if (fr_len_reg == 24'd0) begin
                        state_next = ST_FIN;
                    end else begin
                        phase_next = PH_PAYLOAD;
                        do_ret     = 1'b1;
                    end
                end else begin
                    emit_req            = 1'b1;
                    emit_res.kind       = KIND_EVENT;
                    emit_res.event_code = EV_STREAM_OPENED;
                    do_ret              = 1'b1;
                    if (!sc_found_reg) begin
                        if (sc_ff_reg) begin
                            sm_we                        = 1'b1;
                            slot_valid_next[sc_free_reg] = 1'b1;
                        end else begin
                            emit_res.event_code = EV_TABLE_FULL;
                        end
                    end
                end
            end

            // Frame transmission, one byte a cycle unless the output register stalls.
            ST_TX: begin
                bm_raddr           = BW'(PREFACE_LEN) + BW'(ping_off);
                emit_req           = 1'b1;
                emit_res.kind      = KIND_TX;
                emit_res.out_byte  = tx_byte;
                emit_res.frame_end = (tx_i_reg == tx_total - TW'(1));
                emit_res.stream_ref = (tx_mode_reg == TX_PING) ? fr_stream_reg : 31'd0;
                if (tx_i_reg == tx_total - TW'(1)) begin
                    do_ret = 1'b1;
                end else begin
                    tx_i_next = tx_i_reg + TW'(1);
                end
            end

            // Chunk end: replay an unfinished preface, then drop partial frames; then flush.
            ST_CE: begin
                if (ce_reg && phase_reg == PH_PREFACE) begin
                    rp_active_next = 1'b1;
                    rp_i_next      = 5'd0;
                    rp_n_next      = pidx_reg;
                    phase_next     = PH_HEADER;
                    state_next     = ST_RP_ADDR;
                end else begin
                    if (ce_reg) begin
                        phase_next  = PH_HEADER;
                        hc_next     = 4'd0;
                        hs_next     = '0;
                        prem_next   = 24'd0;
                        cstart_next = 1'b1;
                    end
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                flush_req  = 1'b1;
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Return from the parser: next held byte of a replay, or chunk end.
        if (do_ret) begin
            if (rp_active_reg && (rp_i_reg + 5'd1 < rp_n_reg)) begin
                rp_i_next  = rp_i_reg + 5'd1;
                state_next = ST_RP_ADDR;
            end else begin
                rp_active_next = 1'b0;
                state_next     = ST_CE;
            end
        end
    end

    // A new result displaces the held one; the last of a transaction leaves at flush.
    assign emit_go    = emit_req && (cnt_reg < CW'(MAX_RESULTS));
    assign push_valid = hold_valid_reg && (emit_go || flush_req);
    assign stall      = push_valid && !push_ready;

    always_comb begin
        push_res          = hold_res_reg;
        push_res.run_last = flush_req;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_PREFACE;
            cstart_reg     <= 1'b1;
            pidx_reg       <= 5'd0;
            hs_reg         <= '0;
            hc_reg         <= 4'd0;
            prem_reg       <= 24'd0;
            ec_reg         <= 3'd0;
            dk_reg         <= 1'b0;
            pmask_reg      <= 1'b0;
            pms_reg        <= MAX_STREAMS_RST;
            rp_active_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else if (!stall) begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cstart_reg     <= cstart_next;
            pidx_reg       <= pidx_next;
            hs_reg         <= hs_next;
            hc_reg         <= hc_next;
            prem_reg       <= prem_next;
            ec_reg         <= ec_next;
            dk_reg         <= dk_next;
            pmask_reg      <= pmask_next;
            pms_reg        <= pms_next;
            rp_active_reg  <= rp_active_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!stall) begin
            es_reg        <= es_next;
            fr_len_reg    <= fr_len_next;
            fr_type_reg   <= fr_type_next;
            fr_flags_reg  <= fr_flags_next;
            fr_stream_reg <= fr_stream_next;
            pend_reg      <= pend_next;
            byte_reg      <= byte_next;
            ce_reg        <= ce_next;
            rp_i_reg      <= rp_i_next;
            rp_n_reg      <= rp_n_next;
            tx_mode_reg   <= tx_mode_next;
            tx_i_reg      <= tx_i_next;
            sc_i_reg      <= sc_i_next;
            sc_found_reg  <= sc_found_next;
            sc_ff_reg     <= sc_ff_next;
            sc_free_reg   <= sc_free_next;
        end
    end

    // Result hold register and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end else if (accept) begin
            cnt_reg <= '0;
        end else if (!stall) begin
            if (emit_go) begin
                hold_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + CW'(1);
            end else if (flush_req) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && emit_go) begin
            hold_res_reg <= emit_res;
        end
    end

    // Byte store; a read of an entry written in the same cycle returns the old byte.
    always_ff @(posedge aclk) begin
        if (!stall) begin
            if (bm_we) begin
                bmem[bm_waddr] <= bm_wdata;
            end
            bm_rdata <= bmem[bm_raddr];
        end
    end

    // Stream identifier table.
    always_ff @(posedge aclk) begin
        if (!stall) begin
            if (sm_we) begin
                smem[sc_free_reg] <= fr_stream_reg;
            end
            sm_rdata <= smem[sm_raddr];
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_RESULTS))
        else $error("result count beyond its limit");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("result left in the hold register at idle");

    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && phase_reg == PH_PAYLOAD) |-> (prem_reg != 24'd0))
        else $error("payload phase with nothing remaining");

    a_replay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RP_ADDR) |-> (rp_i_reg < rp_n_reg))
        else $error("replay index beyond held bytes");

    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg < 4'(HDR_LEN))
        else $error("header byte count out of range");
`endif

endmodule

>>> src/http2_frame_receiver.sv
// Top level of the HTTP/2 frame receiver: stream ports, sequencer and output
// register. Depends on hfr_pkg, hfr_core and hfr_out_reg.
//
//  channel  dir  tdata                                   tuser     tlast
//  s_axis   in   rx_byte                                 -         chunk_end
//  m_axis   out  out_byte,frame_end,stream_ref,          kind      run_last
//                end_stream,event_code
//
// A received byte goes through the preface check or the parser; a completed
// frame adds its action and the transmission of any reply frame. Events and
// DATA bytes leave on the way. A replayed preface byte is read from the byte
// store, then parsed. A HEADERS frame or DATA header adds a stream table
// scan, one entry a cycle through the table memory.
// Reset is synchronous and needs no clearing pass: table valid bits are flops.
// A stalled result stops the sequencer until the output register drains.
module http2_frame_receiver #(
    parameter int STREAM_SLOTS = hfr_pkg::STREAM_SLOTS_DEF,
    parameter int PING_BYTES   = hfr_pkg::PING_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [8] frame_end,
                                        // [39:9] stream_ref, [40] end_stream,
                                        // [43:41] event_code, [47:44] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import hfr_pkg::*;

    logic push_valid, push_ready;
    res_t push_res, out_res;

    hfr_core #(
        .STREAM_SLOTS (STREAM_SLOTS),
        .PING_BYTES   (PING_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res)
    );

    hfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_res    (push_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result transaction onto the master side.
    assign m_axis_tdata = {4'd0, out_res.event_code, out_res.end_stream,
                           out_res.stream_ref, out_res.frame_end, out_res.out_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.run_last;

endmodule

>>> sim/tb.sv
// Self-checking testbench of the HTTP/2 frame receiver: directed and random
// byte chunks, with a behavioural predictor of every result the block sends.
// Depends on hfr_pkg and http2_frame_receiver.
module tb;
    import hfr_pkg::*;

    localparam event_t NO_EVENT = EV_SETTINGS_ACK;
    localparam int     N_IDS    = 20;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [30:0] stream_ref;
        logic        end_stream;
        event_t      event_code;
        logic        run_last;
    } result_t;

    typedef struct {
        logic [7:0] rx_byte;
        logic       chunk_end;
        logic       has_exp;
        kind_t      exp_kind;
        event_t     exp_code;
    } rx_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    http2_frame_receiver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // Client connection preface.
    logic [7:0] conn_preface [PREFACE_LEN] = '{
        8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32,
        8'h2E, 8'h30, 8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A};

    // Shadow state of the receiver.
    phase_t      rx_phase;
    logic        chunk_start;
    logic [7:0]  held_preface [PREFACE_LEN];
    int unsigned preface_pos;
    logic [63:0] hdr_bytes;
    int unsigned hdr_count;
    logic [23:0] pay_left;
    logic [47:0] entry_bytes;
    int unsigned entry_count;
    logic [7:0]  ping_payload [PING_BYTES_DEF];
    logic [30:0] slot_stream [STREAM_SLOTS_DEF];
    logic        slot_used [STREAM_SLOTS_DEF];
    logic [31:0] max_streams, init_window, max_frame;
    logic [23:0] f_len;
    logic [7:0]  f_type, f_flags;
    logic [30:0] f_stream;
    logic        data_stream_known;
    logic [2:0]  pend_mask;
    logic [31:0] pend_streams, pend_window, pend_frame;

    result_t     step_results [$];
    result_t     pending_results [$];
    rx_item_t    rx_items [$];
    logic [30:0] id_pool [N_IDS];
    int          errors = 0;
    int          accepted = 0;
    int          total_items = 0;
    logic        sending_done = 1'b0;

    function automatic void put_result(kind_t k, logic [7:0] b, logic fe, logic [30:0] s,
                                       logic es, event_t ev);
        result_t r;
        if (step_results.size() < MAX_RESULTS) begin
            r = '{k, b, fe, s, es, ev, 1'b0};
            step_results.insert(step_results.size(), r);
        end
    endfunction

    function automatic void put_event(event_t ev);
        put_result(KIND_EVENT, 8'h00, 1'b0, f_stream, 1'b0, ev);
    endfunction

    function automatic void put_header(logic [23:0] len, logic [7:0] ft, logic [7:0] fl,
                                       logic [30:0] s, logic last);
        put_result(KIND_TX, len[23:16], 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, len[15:8], 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, len[7:0], 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, ft, 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, fl, 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, {1'b0, s[30:24]}, 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, s[23:16], 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, s[15:8], 1'b0, s, 1'b0, NO_EVENT);
        put_result(KIND_TX, s[7:0], last, s, 1'b0, NO_EVENT);
    endfunction

    function automatic int find_slot(logic [30:0] s);
        for (int i = 0; i < STREAM_SLOTS_DEF; i++)
            if (slot_used[i] && slot_stream[i] == s) return i;
        return -1;
    endfunction

    // Server SETTINGS frame: (1,4096), (2,0), (3,max streams).
    function automatic void put_server_settings();
        logic [7:0] pl [18];
        foreach (pl[i]) pl[i] = 8'h00;
        pl[1] = 8'h01; pl[4] = 8'h10; pl[7] = 8'h02; pl[13] = 8'h03;
        pl[14] = max_streams[31:24]; pl[15] = max_streams[23:16];
        pl[16] = max_streams[15:8];  pl[17] = max_streams[7:0];
        put_header(24'd18, FT_SETTINGS, 8'h00, 31'd0, 1'b0);
        for (int i = 0; i < 18; i++)
            put_result(KIND_TX, pl[i], i == 17, 31'd0, 1'b0, NO_EVENT);
    endfunction

    // Action taken once a whole frame has been received.
    function automatic void close_frame();
        int s;
        logic ack;
        ack = f_flags[0];
        rx_phase = PH_HEADER;
        case (f_type)
            FT_SETTINGS: begin
                if (ack) begin
                    put_event(EV_SETTINGS_ACK);
                end else begin
                    if (pend_mask[0]) max_streams = pend_streams;
                    if (pend_mask[1]) init_window = pend_window;
                    if (pend_mask[2]) max_frame = pend_frame;
                    put_header(24'd0, FT_SETTINGS, 8'h01, 31'd0, 1'b1);
                end
            end
            FT_PING: begin
                if (ack) put_event(EV_PING_ACK);
                else if (f_len > PING_BYTES_DEF) put_event(EV_PING_TOO_LONG);
                else begin
                    put_header(f_len, FT_PING, 8'h01, f_stream, f_len == 0);
                    for (int i = 0; i < f_len; i++)
                        put_result(KIND_TX, ping_payload[i], i + 1 == f_len, f_stream,
                                   1'b0, NO_EVENT);
                end
            end
            FT_HEADERS: begin
                s = find_slot(f_stream);
                if (s < 0) begin
                    for (s = 0; s < STREAM_SLOTS_DEF; s++)
                        if (!slot_used[s]) break;
                    if (s < STREAM_SLOTS_DEF) begin
                        slot_used[s] = 1'b1;
                        slot_stream[s] = f_stream;
                    end
                end
                put_event(s < STREAM_SLOTS_DEF ? EV_STREAM_OPENED : EV_TABLE_FULL);
            end
            FT_DATA: ;
            FT_WINDOW_UPDATE: put_event(EV_WINDOW_UPDATE);
            default: put_event(EV_UNKNOWN_TYPE);
        endcase
    endfunction

    // One byte into the frame parser.
    function automatic void parse_byte(logic [7:0] b);
        logic [23:0] pos;
        if (rx_phase != PH_PAYLOAD) begin
            hdr_bytes = {hdr_bytes[55:0], b};
            hdr_count++;
            if (hdr_count == 3) f_len = hdr_bytes[23:0];
            if (hdr_count >= HDR_LEN) begin
                hdr_count = 0;
                f_type = hdr_bytes[47:40];
                f_flags = hdr_bytes[39:32];
                f_stream = hdr_bytes[30:0];
                hdr_bytes = '0;
                pay_left = f_len;
                entry_bytes = '0;
                entry_count = 0;
                pend_mask = '0;
                data_stream_known = (f_type == FT_DATA) && find_slot(f_stream) >= 0;
                if (f_len == 0) close_frame();
                else rx_phase = PH_PAYLOAD;
            end
            return;
        end
        pos = f_len - pay_left;
        pay_left = pay_left - 1'b1;
        if (f_type == FT_SETTINGS && !f_flags[0]) begin
            entry_bytes = {entry_bytes[39:0], b};
            entry_count++;
            if (entry_count >= 6) begin
                entry_count = 0;
                case (entry_bytes[47:32])
                    16'd3: begin pend_streams = entry_bytes[31:0]; pend_mask[0] = 1'b1; end
                    16'd4: begin pend_window = entry_bytes[31:0]; pend_mask[1] = 1'b1; end
                    16'd5: begin pend_frame = entry_bytes[31:0]; pend_mask[2] = 1'b1; end
                    default: ;
                endcase
            end
        end else if (f_type == FT_PING && !f_flags[0]) begin
            if (pos < PING_BYTES_DEF) ping_payload[pos] = b;
        end else if (f_type == FT_DATA && data_stream_known) begin
            put_result(KIND_DATA, b, pay_left == 0, f_stream, f_flags[0], NO_EVENT);
        end
        if (pay_left == 0) close_frame();
    endfunction

    function automatic void replay_preface();
        rx_phase = PH_HEADER;
        for (int i = 0; i < preface_pos && i < PREFACE_LEN; i++)
            parse_byte(held_preface[i]);
    endfunction

    function automatic void receiver_reset();
        rx_phase = PH_PREFACE;
        chunk_start = 1'b1;
        preface_pos = 0;
        hdr_bytes = '0;
        hdr_count = 0;
        pay_left = '0;
        entry_bytes = '0;
        entry_count = 0;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_stream[i] = '0;
        end
        max_streams = 32'd100;
        init_window = 32'd65535;
        max_frame = 32'd16384;
        f_len = '0; f_type = '0; f_flags = '0; f_stream = '0;
        data_stream_known = 1'b0;
        pend_mask = '0;
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void predict_byte(logic [7:0] b, logic ce);
        int unsigned idx;
        step_results.delete();
        if (chunk_start) begin
            chunk_start = 1'b0;
            rx_phase = PH_PREFACE;
            preface_pos = 0;
        end
        if (rx_phase == PH_PREFACE) begin
            idx = preface_pos >= PREFACE_LEN ? PREFACE_LEN - 1 : preface_pos;
            held_preface[idx] = b;
            preface_pos = idx + 1;
            if (b != conn_preface[idx]) begin
                replay_preface();
            end else if (preface_pos == PREFACE_LEN) begin
                rx_phase = PH_HEADER;
                put_server_settings();
            end
        end else begin
            parse_byte(b);
        end
        if (ce) begin
            if (rx_phase == PH_PREFACE) replay_preface();
            rx_phase = PH_HEADER;
            hdr_count = 0;
            hdr_bytes = '0;
            pay_left = '0;
            chunk_start = 1'b1;
        end
        if (step_results.size() > 0) step_results[$].run_last = 1'b1;
        foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
    endfunction

    // Stimulus building.
    function automatic void add_byte(logic [7:0] b, logic ce = 1'b0, logic chk = 1'b0,
                                     kind_t k = KIND_EVENT, event_t ev = NO_EVENT);
        rx_item_t it;
        it = '{b, ce, chk, k, ev};
        rx_items.insert(rx_items.size(), it);
    endfunction

    function automatic void add_header(logic [23:0] len, logic [7:0] ft, logic [7:0] fl,
                                       logic [30:0] s);
        add_byte(len[23:16]); add_byte(len[15:8]); add_byte(len[7:0]);
        add_byte(ft); add_byte(fl);
        add_byte({$urandom_range(0, 1) == 1, s[30:24]});
        add_byte(s[23:16]); add_byte(s[15:8]); add_byte(s[7:0]);
    endfunction

    function automatic void add_frame();
        int n, sel, extra;
        logic [30:0] s;
        logic [7:0] ft;
        s = id_pool[$urandom_range(0, N_IDS - 1)];
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: begin
                // Whole entries, sometimes followed by a trailing partial entry.
                n = $urandom_range(0, 3);
                extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
                add_header(24'(n * 6 + extra), FT_SETTINGS, 8'($urandom) & 8'hFE, 31'd0);
                for (int e = 0; e < n; e++) begin
                    add_byte(8'h00);
                    add_byte(8'($urandom_range(1, 6)));
                    add_byte(8'($urandom)); add_byte(8'($urandom)); add_byte(8'($urandom));
                    add_byte(8'($urandom_range(0, 255)));
                end
                repeat (extra) add_byte(8'($urandom));
            end
            2: begin
                n = $urandom_range(0, 3);
                add_header(24'(n), FT_SETTINGS, 8'h01, 31'($urandom));
                repeat (n) add_byte(8'($urandom));
            end
            3, 4: begin
                n = $urandom_range(0, 10);
                add_header(24'(n), FT_PING, $urandom_range(0, 3) == 0 ? 8'h01 : 8'h00,
                           31'($urandom));
                repeat (n) add_byte(8'($urandom));
            end
            5: begin
                n = $urandom_range(0, 3);
                add_header(24'(n), FT_HEADERS, 8'($urandom), s);
                repeat (n) add_byte(8'($urandom));
            end
            6, 7: begin
                n = $urandom_range(0, 6);
                add_header(24'(n), FT_DATA, 8'($urandom), s);
                repeat (n) add_byte(8'($urandom));
            end
            8: begin
                add_header(24'd4, FT_WINDOW_UPDATE, 8'($urandom), s);
                repeat (4) add_byte(8'($urandom));
            end
            default: begin
                do ft = 8'($urandom); while (ft == FT_DATA || ft == FT_HEADERS ||
                    ft == FT_SETTINGS || ft == FT_PING || ft == FT_WINDOW_UPDATE);
                n = $urandom_range(0, 3);
                add_header(24'(n), ft, 8'($urandom), s);
                repeat (n) add_byte(8'($urandom));
            end
        endcase
    endfunction

    // One received chunk: optional preface, a few frames, sometimes cut short.
    function automatic void add_chunk();
        int sel, n, cut;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            foreach (conn_preface[i]) add_byte(conn_preface[i]);
        end else if (sel == 3) begin
            n = $urandom_range(1, PREFACE_LEN - 1);
            for (int i = 0; i < n; i++) add_byte(conn_preface[i]);
            if ($urandom_range(0, 1)) add_byte(8'($urandom));
        end
        if (sel == 4) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        end else if (sel == 5) begin
            // Header with an arbitrary length, cut off by the chunk end.
            repeat ($urandom_range(3, 9)) add_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) add_frame();
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, 4);
                while (cut > 0 && rx_items.size() > 1) begin
                    void'(rx_items.pop_back());
                    cut--;
                end
            end
        end
        rx_items[$].chunk_end = 1'b1;
    endfunction

    // Reset, stimulus and the end of the run.
    initial begin
        int gap;
        rx_item_t it;
        receiver_reset();
        foreach (id_pool[i])
            id_pool[i] = i < 4 ? 31'(i + 1) : 31'($urandom_range(1, 32'h7FFFFFFF));
        id_pool[4] = 31'h7FFFFFFF;

        // Directed rows.
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(FT_WINDOW_UPDATE);
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'hFF, 1'b1, 1'b1, KIND_EVENT, EV_WINDOW_UPDATE);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'hFF); add_byte(8'h80); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h01, 1'b1, 1'b1, KIND_EVENT, EV_UNKNOWN_TYPE);
        add_byte(8'h50, 1'b1);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(FT_HEADERS);
        add_byte(8'h05); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h01, 1'b1, 1'b1, KIND_EVENT, EV_STREAM_OPENED);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(FT_PING);
        add_byte(8'h01); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h07, 1'b1, 1'b1, KIND_EVENT, EV_PING_ACK);

        // Random chunks.
        while (rx_items.size() < 160) add_chunk();
        total_items = rx_items.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rx_items[i]) begin
            it = rx_items[i];
            gap = (accepted < total_items * 4 / 5 && $urandom_range(0, 4) == 0)
                  ? $urandom_range(1, 7) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= it.rx_byte;
            s_axis_tlast <= it.chunk_end;
            do @(posedge aclk); while (!s_axis_tready);
            predict_byte(it.rx_byte, it.chunk_end);
            accepted++;
            if (it.has_exp && (step_results.size() == 0 ||
                step_results[$].kind != it.exp_kind ||
                step_results[$].event_code != it.exp_code)) begin
                errors++;
                if (step_results.size() == 0)
                    $display("%0t: row %0d expected kind %0d event %0d, actual no result",
                             $time, i, it.exp_kind, it.exp_code);
                else
                    $display("%0t: row %0d expected kind %0d event %0d, actual kind %0d event %0d",
                             $time, i, it.exp_kind, it.exp_code, step_results[$].kind,
                             step_results[$].event_code);
            end
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        sending_done = 1'b1;

        wait (pending_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result sink: random stall bursts, one long hold-off, none near the end.
    initial begin
        logic held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && accepted >= 60) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (!sending_done && accepted < total_items * 4 / 5 &&
                         $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected one.
    always @(posedge aclk) begin
        result_t want, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{kind_t'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8],
                    m_axis_tdata[39:9], m_axis_tdata[40], event_t'(m_axis_tdata[43:41]),
                    m_axis_tlast};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (want != got) begin
                    errors++;
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, want, got);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
src/hfr_pkg.sv
src/hfr_out_reg.sv
src/hfr_core.sv
src/http2_frame_receiver.sv
sim/tb.sv
